### design/assert_macros.svh
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/bbf_pkg.sv
// Shared types and constants of the bump and best fit allocator.
package bbf_pkg;

   localparam int LIVE_ENTRIES  = 64;
   localparam int SPARE_ENTRIES = 64;
   localparam logic [31:0] MIN_HEAP = 32'd4096;

   localparam int MAX_ENTRIES = (LIVE_ENTRIES > SPARE_ENTRIES) ? LIVE_ENTRIES : SPARE_ENTRIES;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
   localparam logic [2:0] ST_NO_MEMORY = 3'd2;
   localparam logic [2:0] ST_UNKNOWN   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic CSR_INITIAL_SIZE = 1'b0;
   localparam logic CSR_MAX_SIZE     = 1'b1;

   typedef struct packed {
      logic [31:0]      key;
      logic [IDX_W-1:0] idx;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic [31:0]      hit_len;
      logic             best;
      logic [IDX_W-1:0] best_idx;
      logic [31:0]      best_len;
      logic [31:0]      best_start;
      logic             free;
      logic [IDX_W-1:0] free_idx;
   } scan_type;

   typedef struct packed {
      logic        wr;
      logic        clr;
      logic [31:0] start;
      logic [31:0] len;
   } cell_wr_type;

endpackage

### design/bump_and_best_fit_allocator_top.sv
// Bump allocator with a best fit table of freed chunks, top level.
// Each request is accepted, walks the chain of table cells in the scan state,
// and is then settled in the decide state, which updates the tables and waits
// there while an earlier result has not yet been taken. A
// result waits in the output register while the next request is accepted.
// Allocate requests bump the offset, fall back to the smallest freed chunk
// that fits, then grow the heap; free requests move a live block to the freed
// table and report its recorded size.
module bump_and_best_fit_allocator_top import bbf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_size,
   input  logic [31:0] req_pointer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_address,
   output logic [31:0] rsp_freed_size,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

`include "assert_macros.svh"

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      init_ff, max_ff;
   logic [31:0]      offset_ff, offset_in;
   logic [31:0]      grown_ff, grown_in;
   logic             mode_ff;
   logic [31:0]      size_ff, pointer_ff;
   logic [32:0]      end_ff;
   logic [34:0]      big_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff, status_in;
   logic [31:0]      address_ff, address_in;
   logic [31:0]      freed_ff, freed_in;

   scan_type    live_pkt  [LIVE_ENTRIES+1];
   scan_type    spare_pkt [SPARE_ENTRIES+1];
   cell_wr_type live_wr   [LIVE_ENTRIES];
   cell_wr_type spare_wr  [SPARE_ENTRIES];
   scan_type    live_res, spare_res;

   logic        accept, decide;
   logic        live_wr_en, live_clr_en, spare_wr_en, spare_clr_en;
   logic [31:0] live_wr_start, spare_wr_len;
   logic [31:0] heap;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign decide    = (state_ff == S_DECIDE) && !(rsp_valid_ff && !rsp_ready);
   assign live_res  = live_pkt[LIVE_ENTRIES];
   assign spare_res = spare_pkt[SPARE_ENTRIES];

   always_comb begin
      live_pkt[0]      = '0;
      live_pkt[0].key  = pointer_ff;
      spare_pkt[0]     = '0;
      spare_pkt[0].key = size_ff;
   end

   genvar gi;
   generate
      for (gi = 0; gi < LIVE_ENTRIES; gi++) begin : g_live
         always_comb begin
            live_wr[gi].wr    = live_wr_en && (live_res.free_idx == IDX_W'(gi));
            live_wr[gi].clr   = live_clr_en && (live_res.hit_idx == IDX_W'(gi));
            live_wr[gi].start = live_wr_start;
            live_wr[gi].len   = size_ff;
         end
         bbf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .wr      (live_wr[gi]),
            .pkt_in  (live_pkt[gi]),
            .pkt_out (live_pkt[gi+1])
         );
      end
      for (gi = 0; gi < SPARE_ENTRIES; gi++) begin : g_spare
         always_comb begin
            spare_wr[gi].wr    = spare_wr_en && (spare_res.free_idx == IDX_W'(gi));
            spare_wr[gi].clr   = spare_clr_en && (spare_res.best_idx == IDX_W'(gi));
            spare_wr[gi].start = pointer_ff;
            spare_wr[gi].len   = spare_wr_len;
         end
         bbf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .wr      (spare_wr[gi]),
            .pkt_in  (spare_pkt[gi]),
            .pkt_out (spare_pkt[gi+1])
         );
      end
   endgenerate

   always_comb begin
      heap = MIN_HEAP;
      if (init_ff > heap) begin
         heap = init_ff;
      end
      if (grown_ff > heap) begin
         heap = grown_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      offset_in     = offset_ff;
      grown_in      = grown_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      address_in    = address_ff;
      freed_in      = freed_ff;
      live_wr_en    = 1'b0;
      live_clr_en   = 1'b0;
      spare_wr_en   = 1'b0;
      spare_clr_en  = 1'b0;
      live_wr_start = offset_ff;
      spare_wr_len  = live_res.hit_len;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               cnt_in   = '0;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAX_ENTRIES - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (decide) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               freed_in     = '0;
               address_in   = '0;
               status_in    = ST_OK;
               if (mode_ff == MODE_ALLOC) begin
                  if (size_ff == '0) begin
                     status_in = ST_ZERO_SIZE;
                  end else if (end_ff[32]) begin
                     status_in  = ST_NO_MEMORY;
                     address_in = '1;
                  end else if (!live_res.free) begin
                     status_in  = ST_FULL;
                     address_in = '1;
                  end else if ((end_ff[31:0] > heap) && spare_res.best) begin
                     address_in    = spare_res.best_start;
                     live_wr_start = spare_res.best_start;
                     live_wr_en    = 1'b1;
                     spare_clr_en  = 1'b1;
                  end else if ((end_ff[31:0] > heap) && (end_ff[31:0] > max_ff)) begin
                     status_in  = ST_NO_MEMORY;
                     address_in = '1;
                  end else begin
                     if (end_ff[31:0] > heap) begin
                        grown_in = (big_ff < {3'b000, max_ff}) ? big_ff[31:0] : end_ff[31:0];
                     end
                     address_in = offset_ff;
                     offset_in  = end_ff[31:0];
                     live_wr_en = 1'b1;
                  end
               end else begin
                  if (!live_res.hit) begin
                     status_in = ST_UNKNOWN;
                  end else if (!spare_res.free) begin
                     status_in = ST_FULL;
                  end else begin
                     freed_in    = live_res.hit_len;
                     spare_wr_en = 1'b1;
                     live_clr_en = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         offset_ff    <= '0;
         grown_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         init_ff      <= '0;
         max_ff       <= '1;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         offset_ff    <= offset_in;
         grown_ff     <= grown_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_INITIAL_SIZE: init_ff <= csr_wdata;
               CSR_MAX_SIZE:     max_ff  <= csr_wdata;
               default:          init_ff <= init_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_mode;
         size_ff    <= req_size;
         pointer_ff <= req_pointer;
         end_ff     <= {1'b0, offset_ff} + {1'b0, req_size};
         big_ff     <= {3'b000, offset_ff} + {1'b0, req_size, 2'b00};
      end
      status_ff  <= status_in;
      address_ff <= address_in;
      freed_ff   <= freed_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_address    = address_ff;
   assign rsp_freed_size = freed_ff;

   `ASSERT_CLK(a_accept_starts_scan, clock, reset, accept |=> (state_ff == S_SCAN) && (cnt_ff == '0), "request accepted without starting a scan")
   `ASSERT_CLK(a_decide_gives_rsp, clock, reset, decide |=> rsp_valid_ff, "decision made without a response")
   `ASSERT_NEVER(a_live_wr_and_clr, clock, reset, live_wr_en && live_clr_en, "live table written and cleared together")
   `ASSERT_NEVER(a_spare_wr_and_clr, clock, reset, spare_wr_en && spare_clr_en, "freed table written and cleared together")

endmodule

### design/bbf_cell.sv
// One table entry with its stage of the search chain.
module bbf_cell import bbf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cell_wr_type wr,
   input  scan_type    pkt_in,
   output scan_type    pkt_out
);

   logic        valid_ff;
   logic [31:0] start_ff;
   logic [31:0] len_ff;
   scan_type    pkt_ff;
   scan_type    pkt_in_c;
   logic        fit;
   logic        better;

   always_comb begin
      pkt_in_c = pkt_in;
      fit    = valid_ff && (len_ff >= pkt_in.key);
      better = !pkt_in.best || (len_ff < pkt_in.best_len) ||
               ((len_ff == pkt_in.best_len) && (start_ff < pkt_in.best_start));
      pkt_in_c.idx = pkt_in.idx + IDX_W'(1);
      if (valid_ff && !pkt_in.hit && (start_ff == pkt_in.key)) begin
         pkt_in_c.hit     = 1'b1;
         pkt_in_c.hit_idx = pkt_in.idx;
         pkt_in_c.hit_len = len_ff;
      end
      if (fit && better) begin
         pkt_in_c.best       = 1'b1;
         pkt_in_c.best_idx   = pkt_in.idx;
         pkt_in_c.best_len   = len_ff;
         pkt_in_c.best_start = start_ff;
      end
      if (!valid_ff && !pkt_in.free) begin
         pkt_in_c.free     = 1'b1;
         pkt_in_c.free_idx = pkt_in.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.wr) begin
         valid_ff <= 1'b1;
      end else if (wr.clr) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.wr) begin
         start_ff <= wr.start;
         len_ff   <= wr.len;
      end
      pkt_ff <= pkt_in_c;
   end

   assign pkt_out = pkt_ff;

endmodule
